[sv/mean_point_pair_distance_unit_defines.svh]
// assertion macros for the mean point pair distance unit
`ifndef MEAN_POINT_PAIR_DISTANCE_UNIT_DEFINES_SVH
`define MEAN_POINT_PAIR_DISTANCE_UNIT_DEFINES_SVH

// checked only outside reset
`define MPPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MPPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/mppd_pkg.sv]
package mppd_pkg;

    // defaults for the top level parameters
    localparam int unsigned MAX_POINTS_DEF  = 1048576;
    localparam int unsigned COORD_WIDTH_DEF = 24;

    // fixed result and state widths
    localparam int unsigned SUM_W   = 46;
    localparam int unsigned MEAN_W  = 26;
    localparam int unsigned COUNT_W = 21;

    // depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SQRT,
        BK_DIV,
        BK_OUT
    } t_back_state;

    // queue fill status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

[sv/mppd_if.sv]
// pair input channel
interface mppd_pair_if #(
    parameter int unsigned CoordWidth = mppd_pkg::COORD_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         has_pair;
    logic signed [CoordWidth-1:0] a_x;
    logic signed [CoordWidth-1:0] a_y;
    logic signed [CoordWidth-1:0] a_z;
    logic signed [CoordWidth-1:0] b_x;
    logic signed [CoordWidth-1:0] b_y;
    logic signed [CoordWidth-1:0] b_z;
    logic                         is_last;

    modport source (
        output valid, has_pair, a_x, a_y, a_z, b_x, b_y, b_z, is_last,
        input  ready
    );
    modport sink (
        input  valid, has_pair, a_x, a_y, a_z, b_x, b_y, b_z, is_last,
        output ready
    );
endinterface

// result output channel
interface mppd_result_if;
    logic                               valid;
    logic                               ready;
    logic [mppd_pkg::MEAN_W-1:0]        mean_error;
    logic [mppd_pkg::COUNT_W-1:0]       pair_count;
    logic                               empty_set;
    logic                               count_overflow;

    modport source (
        output valid, mean_error, pair_count, empty_set, count_overflow,
        input  ready
    );
    modport sink (
        input  valid, mean_error, pair_count, empty_set, count_overflow,
        output ready
    );
endinterface

[sv/mppd_queue.sv]
module mppd_queue #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = mppd_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [Width-1:0]      i_data,
    input  logic                  i_pop,
    output logic [Width-1:0]      o_data,
    output mppd_pkg::t_queue_stat o_stat
);
    import mppd_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    logic [Width-1:0] r_mem [Depth];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CntW'(Depth));
    assign o_stat.empty = (r_count == '0);

endmodule

[sv/mppd_front.sv]
module mppd_front #(
    parameter int unsigned CoordWidth = mppd_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mppd_pair_if.sink                     i_pair,
    input  mppd_pkg::t_queue_stat         i_queue_stat,
    output logic                          o_push,
    output logic                          o_has_pair,
    output logic                          o_is_last,
    output logic [2*CoordWidth+1:0]       o_sumsq
);
    import mppd_pkg::*;

    localparam int unsigned DW  = CoordWidth + 1;
    localparam int unsigned SQW = 2 * CoordWidth + 1;
    localparam int unsigned SSW = 2 * CoordWidth + 2;

    logic signed [CoordWidth-1:0] a_c [3];
    logic signed [CoordWidth-1:0] b_c [3];
    logic [DW-1:0]                mag [3];
    logic [2*DW-1:0]              prod [3];

    logic                r_v1, r_v2, r_v3;
    logic                r_hp1, r_hp2, r_hp3;
    logic                r_last1, r_last2, r_last3;
    logic signed [DW-1:0] r_d [3];
    logic [SQW-1:0]      r_sq [3];
    logic [SSW-1:0]      r_sumsq;
    logic                rdy1, rdy2, rdy3;

    assign a_c[0] = i_pair.a_x;
    assign a_c[1] = i_pair.a_y;
    assign a_c[2] = i_pair.a_z;
    assign b_c[0] = i_pair.b_x;
    assign b_c[1] = i_pair.b_y;
    assign b_c[2] = i_pair.b_z;

    // stall chain, each stage moves when the next can take it
    assign rdy3         = !r_v3 || !i_queue_stat.full;
    assign rdy2         = !r_v2 || rdy3;
    assign rdy1         = !r_v1 || rdy2;
    assign i_pair.ready = rdy1;

    // magnitude of each difference and its square
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i]  = r_d[i][DW-1] ? DW'(-r_d[i]) : DW'(r_d[i]);
            prod[i] = mag[i] * mag[i];
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_pair.valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // stage payloads: differences, squares, sum of squares
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_hp1   <= i_pair.has_pair;
            r_last1 <= i_pair.is_last;
            for (int i = 0; i < 3; i++) begin
                r_d[i] <= {a_c[i][CoordWidth-1], a_c[i]} - {b_c[i][CoordWidth-1], b_c[i]};
            end
        end
        if (rdy2) begin
            r_hp2   <= r_hp1;
            r_last2 <= r_last1;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= prod[i][SQW-1:0];
            end
        end
        if (rdy3) begin
            r_hp3   <= r_hp2;
            r_last3 <= r_last2;
            r_sumsq <= SSW'(r_sq[0]) + SSW'(r_sq[1]) + SSW'(r_sq[2]);
        end
    end

    assign o_push     = r_v3 && !i_queue_stat.full;
    assign o_has_pair = r_hp3;
    assign o_is_last  = r_last3;
    assign o_sumsq    = r_sumsq;

endmodule

[sv/mppd_back.sv]
module mppd_back #(
    parameter int unsigned CoordWidth = mppd_pkg::COORD_WIDTH_DEF,
    parameter int unsigned MaxPoints  = mppd_pkg::MAX_POINTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mppd_pkg::t_queue_stat   i_queue_stat,
    input  logic                    i_has_pair,
    input  logic                    i_is_last,
    input  logic [2*CoordWidth+1:0] i_sumsq,
    output logic                    o_pop,
    mppd_result_if.source           o_result
);
    import mppd_pkg::*;

    localparam int unsigned SSW = 2 * CoordWidth + 2;
    localparam int unsigned RW  = CoordWidth + 1;
    localparam int unsigned IW  = $clog2(RW);
    localparam int unsigned DIW = $clog2(SUM_W);

    t_back_state r_state, n_state;

    // square root unit
    logic [SSW-1:0]   r_rad;
    logic [RW+1:0]    r_rem;
    logic [RW-1:0]    r_root;
    logic [IW-1:0]    r_it;
    logic [RW+1:0]    rem_sh, trial, n_rem;
    logic [RW-1:0]    n_root;
    logic             sq_ge;

    // accumulator
    logic               r_last;
    logic [SUM_W-1:0]   r_sum;
    logic [COUNT_W-1:0] r_count;
    logic               r_ovf;
    logic [SUM_W-1:0]   new_sum;
    logic               at_cap;

    // divider
    logic [SUM_W-1:0]   r_quo;
    logic [COUNT_W:0]   r_drem;
    logic [COUNT_W-1:0] r_div;
    logic [DIW-1:0]     r_dit;
    logic [COUNT_W:0]   drem_sh;
    logic               dv_ge;

    // output register
    logic               r_out_valid;
    logic [MEAN_W-1:0]  r_mean;
    logic [COUNT_W-1:0] r_ocount;
    logic               r_empty;
    logic               r_oovf;

    // sequencer controls
    logic start_sqrt, skip_to_div, sqrt_done, div_done, out_load;

    assign at_cap = (r_count >= COUNT_W'(MaxPoints));

    // one root bit per cycle
    always_comb begin
        rem_sh = {r_rem[RW-1:0], r_rad[SSW-1:SSW-2]};
        trial  = {r_root, 2'b01};
        sq_ge  = (rem_sh >= trial);
        n_rem  = sq_ge ? rem_sh - trial : rem_sh;
        n_root = {r_root[RW-2:0], sq_ge};
    end

    assign new_sum = r_sum + SUM_W'(n_root);

    // one quotient bit per cycle
    assign drem_sh = {r_drem[COUNT_W-1:0], r_quo[SUM_W-1]};
    assign dv_ge   = (drem_sh >= {1'b0, r_div});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_queue_stat.empty) begin
                    if (i_has_pair && !at_cap) begin
                        n_state = BK_SQRT;
                    end else if (i_is_last) begin
                        n_state = BK_DIV;
                    end
                end
            end
            BK_SQRT: begin
                if (r_it == IW'(RW - 1)) begin
                    n_state = r_last ? BK_DIV : BK_IDLE;
                end
            end
            BK_DIV: begin
                if (r_dit == DIW'(SUM_W - 1)) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_pop       = (r_state == BK_IDLE) && !i_queue_stat.empty;
        start_sqrt  = o_pop && i_has_pair && !at_cap;
        skip_to_div = o_pop && !(i_has_pair && !at_cap) && i_is_last;
        sqrt_done   = (r_state == BK_SQRT) && (r_it == IW'(RW - 1));
        div_done    = (r_state == BK_DIV) && (r_dit == DIW'(SUM_W - 1));
        out_load    = (r_state == BK_OUT) && (!r_out_valid || o_result.ready);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_sum       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && i_has_pair && at_cap) begin
                r_ovf <= 1'b1;
            end
            if (sqrt_done) begin
                r_sum   <= new_sum;
                r_count <= r_count + 1'b1;
            end
            if (out_load) begin
                r_sum       <= '0;
                r_count     <= '0;
                r_ovf       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_last <= i_is_last;
        end
        if (start_sqrt) begin
            r_rad  <= i_sumsq;
            r_rem  <= '0;
            r_root <= '0;
            r_it   <= '0;
        end else if (r_state == BK_SQRT) begin
            r_rad  <= r_rad << 2;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_it   <= r_it + 1'b1;
        end
        if (skip_to_div) begin
            r_quo  <= r_sum;
            r_div  <= r_count;
            r_drem <= '0;
            r_dit  <= '0;
        end else if (sqrt_done) begin
            r_quo  <= new_sum;
            r_div  <= r_count + 1'b1;
            r_drem <= '0;
            r_dit  <= '0;
        end else if (r_state == BK_DIV) begin
            r_quo  <= {r_quo[SUM_W-2:0], dv_ge};
            r_drem <= dv_ge ? drem_sh - {1'b0, r_div} : drem_sh;
            r_dit  <= div_done ? r_dit : r_dit + 1'b1;
        end
        if (out_load) begin
            r_empty  <= (r_count == '0);
            r_mean   <= (r_count == '0) ? '0 : r_quo[MEAN_W-1:0];
            r_ocount <= r_count;
            r_oovf   <= r_ovf;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.mean_error     = r_mean;
    assign o_result.pair_count     = r_ocount;
    assign o_result.empty_set      = r_empty;
    assign o_result.count_overflow = r_oovf;

endmodule

[sv/mean_point_pair_distance_unit.sv]
// data passes the difference/square/sum front stages, then the queue, then the
// square root per pair; a last item adds the divide and the output register.
// the back end pops the next pair only once the previous root is done, so the
// rate is set by the one-bit-per-cycle square root unit in the back end.
// reset: synchronous active low; clears the sum, count, overflow flag, queue
// and output valid, and no clearing pass is needed.
`include "mean_point_pair_distance_unit_defines.svh"

module mean_point_pair_distance_unit #(
    parameter int unsigned MaxPoints  = mppd_pkg::MAX_POINTS_DEF,
    parameter int unsigned CoordWidth = mppd_pkg::COORD_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mppd_pair_if.sink     i_pair,
    mppd_result_if.source o_result
);
    import mppd_pkg::*;

    localparam int unsigned SSW = 2 * CoordWidth + 2;
    localparam int unsigned QW  = SSW + 2;

    t_queue_stat    queue_stat;
    logic           push, pop;
    logic           f_has_pair, f_is_last;
    logic [SSW-1:0] f_sumsq;
    logic [QW-1:0]  q_data;

    // distance front
    mppd_front #(
        .CoordWidth(CoordWidth)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pair      (i_pair),
        .i_queue_stat(queue_stat),
        .o_push      (push),
        .o_has_pair  (f_has_pair),
        .o_is_last   (f_is_last),
        .o_sumsq     (f_sumsq)
    );

    // decoupling queue
    mppd_queue #(
        .Width(QW),
        .Depth(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({f_has_pair, f_is_last, f_sumsq}),
        .i_pop  (pop),
        .o_data (q_data),
        .o_stat (queue_stat)
    );

    // root, accumulate and mean
    mppd_back #(
        .CoordWidth(CoordWidth),
        .MaxPoints (MaxPoints)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_queue_stat(queue_stat),
        .i_has_pair  (q_data[QW-1]),
        .i_is_last   (q_data[QW-2]),
        .i_sumsq     (q_data[SSW-1:0]),
        .o_pop       (pop),
        .o_result    (o_result)
    );

    // checks
    `MPPD_ASSERT(a_no_push_full, push |-> !queue_stat.full, "push into full queue")
    `MPPD_ASSERT(a_no_pop_empty, pop |-> !queue_stat.empty, "pop from empty queue")
    `MPPD_ASSERT(a_empty_mean, o_result.valid && o_result.empty_set |-> o_result.mean_error == '0 && o_result.pair_count == '0, "empty set with nonzero result")
    `MPPD_ASSERT_ALWAYS(a_count_cap, o_result.valid |-> o_result.pair_count <= COUNT_W'(MaxPoints), "pair count above capacity")

endmodule
